/* hdl/ocu_pkg.sv */
`timescale 1ns / 1ps

package ocu_pkg;

    localparam int SENS_W     = 16;
    localparam int RAD_W      = 19;
    localparam int CFG_W      = 19;
    localparam int CFG_IDX_W  = 1;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_IDX_W-1:0] REG_SENSITIVITY  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ORBIT_RADIUS = 1'b1;

    localparam logic [SENS_W-1:0] SENS_RESET = 16'd2560;
    localparam logic [RAD_W-1:0]  RAD_RESET  = 19'd17920;

    // shared multiplier geometry
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 33;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // sine polynomial coefficients, q30
    localparam logic [31:0] SIN_C1 = 32'd1686629713;
    localparam logic [31:0] SIN_C3 = 32'd693598668;
    localparam logic [31:0] SIN_C5 = 32'd85569306;
    localparam logic [31:0] SIN_C7 = 32'd5026995;
    localparam logic [31:0] SIN_C9 = 32'd172272;

    localparam logic [23:0] QUARTER_TURN   = 24'h400000;
    localparam logic [22:0] QUARTER_FOLD   = 23'h400000;
    localparam logic [22:0] PITCH_DIVIDEND = 23'h400000;
    localparam logic [31:0] SIN_ROUND      = 32'd8192;
    localparam logic [17:0] SIN_MAX        = 18'd65536;
    localparam logic [31:0] YAW_BIAS       = 32'd16384;
    localparam logic signed [35:0] HEIGHT_Q8 = 36'sd2176;
    localparam logic signed [35:0] S32_MAX = 36'sd2147483647;
    localparam logic signed [35:0] S32_MIN = -36'sd2147483648;

    localparam logic [4:0] DIV_LAST  = 5'd22;
    localparam logic [4:0] POLY_LAST = 5'd3;

    typedef struct packed {
        logic signed [15:0] mouse_dx;
        logic signed [15:0] mouse_dy;
        logic signed [15:0] pad_dx;
        logic signed [15:0] pad_dy;
        logic signed [31:0] char_x;
        logic signed [31:0] char_y;
        logic signed [31:0] char_z;
        logic               bypass;
    } item_t;

    typedef struct packed {
        logic signed [31:0] cam_x;
        logic signed [31:0] cam_y;
        logic signed [31:0] cam_z;
        logic signed [15:0] cam_pitch;
        logic signed [31:0] cam_yaw;
        logic               updated;
    } result_t;

    typedef enum logic {
        KIND_FRAME,
        KIND_BYPASS
    } kind_t;

    typedef struct packed {
        kind_t kind;
        item_t item;
    } entry_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DIV,
        ST_ACC,
        ST_MYAW,
        ST_MPIT,
        ST_FOLD,
        ST_X2,
        ST_C9,
        ST_POLY,
        ST_RND,
        ST_MCC,
        ST_MXO,
        ST_MZS,
        ST_MZO,
        ST_MYO,
        ST_FIN,
        ST_OUT
    } state_t;

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        logic signed [31:0] r;
        if (v > S32_MAX)
            r = S32_MAX[31:0];
        else if (v < S32_MIN)
            r = S32_MIN[31:0];
        else
            r = v[31:0];
        return r;
    endfunction

    // minus the q8 value truncated toward zero
    function automatic logic [39:0] neg_trunc_q8(input logic signed [47:0] v);
        logic [47:0] mag;
        logic [39:0] q;
        mag = v[47] ? 48'(-v) : 48'(v);
        q   = mag[47:8];
        return v[47] ? q : 40'(-q);
    endfunction

endpackage

/* hdl/ocu_if.sv */
`timescale 1ns / 1ps

interface ocu_item_if;
    logic           valid;
    logic           ready;
    ocu_pkg::item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ocu_result_if;
    logic             valid;
    logic             ready;
    ocu_pkg::result_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* hdl/ocu_front.sv */
`timescale 1ns / 1ps

module ocu_front #(
    parameter int DEPTH = ocu_pkg::QUEUE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    ocu_item_if.sink        item,
    input  logic            pop,
    output logic            q_valid,
    output ocu_pkg::entry_t q_head
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    ocu_pkg::entry_t  slots [DEPTH];
    ocu_pkg::entry_t  in_entry;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;

    assign item.ready = (count_reg != CNT_W'(DEPTH));
    assign push       = item.valid & item.ready;
    assign q_valid    = (count_reg != '0);
    assign q_head     = slots[rd_ptr_reg];

    // tag each request so the back end can branch at once
    always_comb
    begin
        in_entry.item = item.data;
        in_entry.kind = item.data.bypass ? ocu_pkg::KIND_BYPASS : ocu_pkg::KIND_FRAME;
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots[wr_ptr_reg] <= in_entry;
    end

endmodule

/* hdl/ocu_back.sv */
`timescale 1ns / 1ps

module ocu_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_valid,
    input  ocu_pkg::entry_t              q_head,
    output logic                         pop,
    input  logic [ocu_pkg::SENS_W-1:0]   sens,
    input  logic [ocu_pkg::RAD_W-1:0]    rad,
    ocu_result_if.source                 result
);

    ocu_pkg::state_t  state_reg, state_next;
    logic [4:0]       cnt_reg, cnt_next;
    logic [1:0]       sidx_reg, sidx_next;
    logic             out_valid_reg, out_valid_next;
    logic signed [31:0] yaw_total_reg, yaw_total_next;
    logic signed [23:0] pitch_total_reg, pitch_total_next;

    ocu_pkg::item_t   item_reg, item_next;
    logic [15:0]      rem_reg, rem_next;
    logic [22:0]      divd_reg, divd_next;
    logic [22:0]      quo_reg, quo_next;
    logic signed [ocu_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic [23:0]      yaw_ph_reg, yaw_ph_next;
    logic [23:0]      pit_ph_reg, pit_ph_next;
    logic [30:0]      x_reg, x_next;
    logic [1:0]       quad_reg, quad_next;
    logic [30:0]      x2_reg, x2_next;
    logic signed [17:0] sin_reg [4];
    logic signed [17:0] sin_next;
    logic             sin_we;
    ocu_pkg::result_t wrk_reg, wrk_next;
    ocu_pkg::result_t res_reg;
    logic             load_out;

    logic signed [ocu_pkg::MUL_A_W-1:0] mul_a;
    logic signed [ocu_pkg::MUL_B_W-1:0] mul_b;

    logic signed [15:0] dxm, dym, dxp, dyp;
    logic signed [31:0] cx, cy, cz;
    logic [16:0]        rem_sh;
    logic [17:0]        trial;
    logic               ge;
    logic signed [33:0] yaw_sum;
    logic signed [25:0] pitch_sum, maxy_s, pitch_lim;
    logic [39:0]        ntr_yaw, ntr_pitch;
    logic signed [39:0] ppitch;
    logic [23:0]        phase_sel;
    logic [22:0]        fold_f;
    logic [31:0]        poly_c, poly_r;
    logic [31:0]        rnd_t;
    logic [17:0]        rnd_mag;
    logic signed [ocu_pkg::PROD_W-1:0] sum_xz, sum_y;
    logic signed [34:0] off_xz;
    logic signed [35:0] off_y;
    logic signed [35:0] px, py, pz;

    assign dxm = item_reg.mouse_dx;
    assign dym = item_reg.mouse_dy;
    assign dxp = item_reg.pad_dx;
    assign dyp = item_reg.pad_dy;
    assign cx  = item_reg.char_x;
    assign cy  = item_reg.char_y;
    assign cz  = item_reg.char_z;

    // restoring divide step for the pitch limit
    assign rem_sh = {rem_reg, divd_reg[22]};
    assign trial  = {1'b0, rem_sh} - {2'b0, sens};
    assign ge     = ~trial[17];

    assign yaw_sum   = 34'(yaw_total_reg) + 34'(dxm) + 34'(dxp);
    assign pitch_sum = 26'(pitch_total_reg) + 26'(dym) + 26'(dyp);
    assign maxy_s    = {3'b000, quo_reg};
    always_comb
    begin
        if (pitch_sum > maxy_s)
            pitch_lim = maxy_s;
        else if (pitch_sum < -maxy_s)
            pitch_lim = -maxy_s;
        else
            pitch_lim = pitch_sum;
    end

    assign ntr_yaw   = ocu_pkg::neg_trunc_q8(prod_reg[47:0]);
    assign ppitch    = prod_reg[39:0];
    assign ntr_pitch = ocu_pkg::neg_trunc_q8(48'(ppitch));

    // phase select and quadrant fold
    always_comb
    begin
        case (sidx_reg)
            2'd0:    phase_sel = yaw_ph_reg;
            2'd1:    phase_sel = yaw_ph_reg + ocu_pkg::QUARTER_TURN;
            2'd2:    phase_sel = pit_ph_reg;
            default: phase_sel = pit_ph_reg + ocu_pkg::QUARTER_TURN;
        endcase
        fold_f = phase_sel[22] ? ocu_pkg::QUARTER_FOLD - {1'b0, phase_sel[21:0]}
                               : {1'b0, phase_sel[21:0]};
    end

    always_comb
    begin
        case (cnt_reg[1:0])
            2'd0:    poly_c = ocu_pkg::SIN_C7;
            2'd1:    poly_c = ocu_pkg::SIN_C5;
            2'd2:    poly_c = ocu_pkg::SIN_C3;
            default: poly_c = ocu_pkg::SIN_C1;
        endcase
        poly_r = poly_c - {1'b0, prod_reg[60:30]};
    end

    // round to q16 and limit to one
    assign rnd_t   = {1'b0, prod_reg[60:30]} + ocu_pkg::SIN_ROUND;
    assign rnd_mag = (rnd_t[31:14] > ocu_pkg::SIN_MAX) ? ocu_pkg::SIN_MAX : rnd_t[31:14];
    assign sin_next = quad_reg[1] ? -$signed(rnd_mag) : $signed(rnd_mag);

    assign sum_xz = prod_reg + (ocu_pkg::PROD_W'(1) <<< 31);
    assign sum_y  = prod_reg + (ocu_pkg::PROD_W'(1) <<< 15);
    assign off_xz = sum_xz[66:32];
    assign off_y  = sum_y[51:16];
    assign px = 36'(cx) + 36'(off_xz);
    assign pz = 36'(cz) + 36'(off_xz);
    assign py = 36'(cy) + ocu_pkg::HEIGHT_Q8 + off_y;

    assign prod_next = ocu_pkg::PROD_W'(mul_a) * ocu_pkg::PROD_W'(mul_b);

    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        sidx_next        = sidx_reg;
        yaw_total_next   = yaw_total_reg;
        pitch_total_next = pitch_total_reg;
        item_next        = item_reg;
        rem_next         = rem_reg;
        divd_next        = divd_reg;
        quo_next         = quo_reg;
        yaw_ph_next      = yaw_ph_reg;
        pit_ph_next      = pit_ph_reg;
        x_next           = x_reg;
        quad_next        = quad_reg;
        x2_next          = x2_reg;
        wrk_next         = wrk_reg;
        sin_we           = 1'b0;
        pop              = 1'b0;
        load_out         = 1'b0;
        mul_a            = '0;
        mul_b            = '0;
        unique case (state_reg)
            ocu_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    pop       = 1'b1;
                    item_next = q_head.item;
                    rem_next  = '0;
                    divd_next = ocu_pkg::PITCH_DIVIDEND;
                    quo_next  = '0;
                    cnt_next  = '0;
                    sidx_next = '0;
                    if (q_head.kind == ocu_pkg::KIND_BYPASS)
                    begin
                        wrk_next   = '0;
                        state_next = ocu_pkg::ST_OUT;
                    end
                    else
                        state_next = ocu_pkg::ST_DIV;
                end
            end
            ocu_pkg::ST_DIV:
            begin
                rem_next  = ge ? trial[15:0] : rem_sh[15:0];
                quo_next  = {quo_reg[21:0], ge};
                divd_next = {divd_reg[21:0], 1'b0};
                if (cnt_reg == ocu_pkg::DIV_LAST)
                    state_next = ocu_pkg::ST_ACC;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ocu_pkg::ST_ACC:
            begin
                yaw_total_next   = ocu_pkg::sat32(36'(yaw_sum));
                pitch_total_next = pitch_lim[23:0];
                state_next       = ocu_pkg::ST_MYAW;
            end
            ocu_pkg::ST_MYAW:
            begin
                mul_a      = 34'(yaw_total_reg);
                mul_b      = {17'b0, sens};
                state_next = ocu_pkg::ST_MPIT;
            end
            ocu_pkg::ST_MPIT:
            begin
                mul_a            = 34'(pitch_total_reg);
                mul_b            = {17'b0, sens};
                yaw_ph_next      = prod_reg[23:0];
                wrk_next.cam_yaw = ntr_yaw[31:0] + ocu_pkg::YAW_BIAS;
                state_next       = ocu_pkg::ST_FOLD;
            end
            ocu_pkg::ST_FOLD:
            begin
                // first pass still sees the pitch angle product
                if (sidx_reg == 2'd0)
                begin
                    pit_ph_next        = prod_reg[23:0];
                    wrk_next.cam_pitch = ntr_pitch[15:0];
                end
                x_next     = {fold_f, 8'b0};
                quad_next  = phase_sel[23:22];
                state_next = ocu_pkg::ST_X2;
            end
            ocu_pkg::ST_X2:
            begin
                mul_a      = {3'b0, x_reg};
                mul_b      = {2'b0, x_reg};
                state_next = ocu_pkg::ST_C9;
            end
            ocu_pkg::ST_C9:
            begin
                x2_next    = prod_reg[60:30];
                mul_a      = {3'b0, prod_reg[60:30]};
                mul_b      = {1'b0, ocu_pkg::SIN_C9};
                cnt_next   = '0;
                state_next = ocu_pkg::ST_POLY;
            end
            ocu_pkg::ST_POLY:
            begin
                mul_a = (cnt_reg == ocu_pkg::POLY_LAST) ? {3'b0, x_reg} : {3'b0, x2_reg};
                mul_b = {1'b0, poly_r};
                if (cnt_reg == ocu_pkg::POLY_LAST)
                    state_next = ocu_pkg::ST_RND;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ocu_pkg::ST_RND:
            begin
                sin_we = 1'b1;
                if (sidx_reg == 2'd3)
                    state_next = ocu_pkg::ST_MCC;
                else
                begin
                    sidx_next  = sidx_reg + 1'b1;
                    state_next = ocu_pkg::ST_FOLD;
                end
            end
            ocu_pkg::ST_MCC:
            begin
                mul_a      = 34'(sin_reg[1]);
                mul_b      = 33'(sin_reg[3]);
                state_next = ocu_pkg::ST_MXO;
            end
            ocu_pkg::ST_MXO:
            begin
                mul_a      = prod_reg[33:0];
                mul_b      = {14'b0, rad};
                state_next = ocu_pkg::ST_MZS;
            end
            ocu_pkg::ST_MZS:
            begin
                wrk_next.cam_x = ocu_pkg::sat32(px);
                mul_a          = 34'(sin_reg[0]);
                mul_b          = 33'(sin_reg[3]);
                state_next     = ocu_pkg::ST_MZO;
            end
            ocu_pkg::ST_MZO:
            begin
                mul_a      = prod_reg[33:0];
                mul_b      = {14'b0, rad};
                state_next = ocu_pkg::ST_MYO;
            end
            ocu_pkg::ST_MYO:
            begin
                wrk_next.cam_z = ocu_pkg::sat32(pz);
                mul_a          = 34'(sin_reg[2]);
                mul_b          = {14'b0, rad};
                state_next     = ocu_pkg::ST_FIN;
            end
            ocu_pkg::ST_FIN:
            begin
                wrk_next.cam_y   = ocu_pkg::sat32(py);
                wrk_next.updated = 1'b1;
                state_next       = ocu_pkg::ST_OUT;
            end
            ocu_pkg::ST_OUT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    load_out   = 1'b1;
                    state_next = ocu_pkg::ST_IDLE;
                end
            end
            default:
                state_next = ocu_pkg::ST_IDLE;
        endcase
    end

    assign out_valid_next = load_out | (out_valid_reg & ~result.ready);
    assign result.valid   = out_valid_reg;
    assign result.data    = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ocu_pkg::ST_IDLE;
            cnt_reg         <= '0;
            sidx_reg        <= '0;
            out_valid_reg   <= 1'b0;
            yaw_total_reg   <= '0;
            pitch_total_reg <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            sidx_reg        <= sidx_next;
            out_valid_reg   <= out_valid_next;
            yaw_total_reg   <= yaw_total_next;
            pitch_total_reg <= pitch_total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        rem_reg    <= rem_next;
        divd_reg   <= divd_next;
        quo_reg    <= quo_next;
        prod_reg   <= prod_next;
        yaw_ph_reg <= yaw_ph_next;
        pit_ph_reg <= pit_ph_next;
        x_reg      <= x_next;
        quad_reg   <= quad_next;
        x2_reg     <= x2_next;
        wrk_reg    <= wrk_next;
        if (sin_we)
            sin_reg[sidx_reg] <= sin_next;
        if (load_out)
            res_reg <= wrk_reg;
    end

endmodule

/* hdl/orbit_camera_update_unit.sv */
`timescale 1ns / 1ps

// orbit camera update: each request carries mouse and pad deltas, the followed
// character's position and a bypass flag; the unit keeps yaw and pitch
// accumulators and returns one result per request with the camera position
// (signed q23.8), the negated pitch angle and the negated yaw angle plus a
// quarter turn. between input queue and output register a frame request passes
// the one-bit-a-cycle divider that forms the pitch limit from the sensitivity,
// an accumulate and clamp step, two angle multiplies, the sine and cosine of
// each angle on the single shared 34x33 multiplier, the three position offsets
// and the hand-over. a bypass request leaves the accumulators alone. the input
// queue accepts requests whenever not full (QUEUE_DEPTH entries), also while
// the back end computes and while a finished result waits in the output
// register. sensitivity and orbit_radius must be written through cfg_we/
// cfg_index/cfg_data only while idle; the block itself does not enforce this.

module orbit_camera_update_unit #(
    parameter int QUEUE_DEPTH = ocu_pkg::QUEUE_DEPTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    ocu_item_if.sink                        item,
    ocu_result_if.source                    result,
    input  logic                            cfg_we,
    input  logic [ocu_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ocu_pkg::CFG_W-1:0]       cfg_data
);

    // configuration registers
    logic [ocu_pkg::SENS_W-1:0] sens_reg, sens_next;
    logic [ocu_pkg::RAD_W-1:0]  rad_reg, rad_next;

    // front to back link
    logic            q_valid;
    logic            pop;
    ocu_pkg::entry_t q_head;

    always_comb
    begin
        sens_next = sens_reg;
        rad_next  = rad_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                ocu_pkg::REG_SENSITIVITY:  sens_next = cfg_data[ocu_pkg::SENS_W-1:0];
                ocu_pkg::REG_ORBIT_RADIUS: rad_next  = cfg_data[ocu_pkg::RAD_W-1:0];
                default:                   sens_next = sens_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sens_reg <= ocu_pkg::SENS_RESET;
            rad_reg  <= ocu_pkg::RAD_RESET;
        end
        else
        begin
            sens_reg <= sens_next;
            rad_reg  <= rad_next;
        end
    end

    // accepts requests and tags bypass ones
    ocu_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .pop     (pop),
        .q_valid (q_valid),
        .q_head  (q_head)
    );

    // accumulators, sine/cosine sequencer, position math and output register
    ocu_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_head  (q_head),
        .pop     (pop),
        .sens    (sens_reg),
        .rad     (rad_reg),
        .result  (result)
    );

endmodule

/* tb/tb_orbit_camera_update_unit.sv */
`timescale 1ns / 1ps

// keeps its own yaw/pitch accumulators and register copies, predicts each result
// when a request is accepted and checks results in order
class camera_scoreboard;
    int unsigned sens;
    int unsigned radius;
    int          yaw_acc;
    int          pitch_acc;
    ocu_pkg::result_t expected_q[$];
    int          mismatches;
    int          accepted;

    function new();
        sens       = ocu_pkg::SENS_RESET;
        radius     = ocu_pkg::RAD_RESET;
        yaw_acc    = 0;
        pitch_acc  = 0;
        mismatches = 0;
        accepted   = 0;
    endfunction

    function void set_reg(logic [ocu_pkg::CFG_IDX_W-1:0] idx, logic [ocu_pkg::CFG_W-1:0] val);
        if (idx == ocu_pkg::REG_SENSITIVITY)
            sens = val[15:0];
        else
            radius = val;
    endfunction

    // q16 sine of a 24-bit binary angle, odd polynomial on the folded quadrant
    function longint sine_q16(logic [23:0] ph);
        longint unsigned f, x, x2, r, s;
        f = ph[21:0];
        if (ph[22])
            f = 64'h400000 - f;
        x  = f << 8;
        x2 = (x * x) >> 30;
        r  = ocu_pkg::SIN_C9;
        r  = ocu_pkg::SIN_C7 - ((x2 * r) >> 30);
        r  = ocu_pkg::SIN_C5 - ((x2 * r) >> 30);
        r  = ocu_pkg::SIN_C3 - ((x2 * r) >> 30);
        r  = ocu_pkg::SIN_C1 - ((x2 * r) >> 30);
        s  = (x * r) >> 30;
        s  = (s + 8192) >> 14;
        if (s > 65536)
            s = 65536;
        return ph[23] ? -longint'(s) : longint'(s);
    endfunction

    function longint clip32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function void note_request(ocu_pkg::item_t it);
        ocu_pkg::result_t res;
        longint yaw, pitch, lim, pyaw, ppitch, sy, cy, sp, cp, rad;
        logic [23:0] qt;
        accepted++;
        res = '0;
        if (!it.bypass)
        begin
            qt    = ocu_pkg::QUARTER_TURN;
            rad   = radius;
            yaw   = clip32(longint'(yaw_acc) + it.mouse_dx + it.pad_dx);
            pitch = longint'(pitch_acc) + it.mouse_dy + it.pad_dy;
            lim   = (sens == 0) ? 8388607 : 4194304 / sens;
            if (pitch < -lim)
                pitch = -lim;
            if (pitch > lim)
                pitch = lim;
            yaw_acc   = int'(yaw);
            pitch_acc = int'(pitch);
            pyaw   = yaw * sens;
            ppitch = pitch * sens;
            sy = sine_q16(pyaw[23:0]);
            cy = sine_q16(pyaw[23:0] + qt);
            sp = sine_q16(ppitch[23:0]);
            cp = sine_q16(ppitch[23:0] + qt);
            res.cam_x = clip32(it.char_x + ((rad * cy * cp + (64'sd1 <<< 31)) >>> 32));
            res.cam_y = clip32(it.char_y + 2176 + ((rad * sp + (64'sd1 <<< 15)) >>> 16));
            res.cam_z = clip32(it.char_z + ((rad * sy * cp + (64'sd1 <<< 31)) >>> 32));
            res.cam_pitch = 16'(-(ppitch / 256));
            res.cam_yaw   = 32'(-(pyaw / 256) + 16384);
            res.updated   = 1'b1;
        end
        expected_q.push_back(res);
    endfunction

    function void field(string name, longint e, longint a);
        if (e != a)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %0d got %0d", name, e, a);
        end
    endfunction

    function void check_result(ocu_pkg::result_t got);
        ocu_pkg::result_t e;
        if (expected_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: %p", got);
            return;
        end
        e = expected_q.pop_front();
        field("cam_x", e.cam_x, got.cam_x);
        field("cam_y", e.cam_y, got.cam_y);
        field("cam_z", e.cam_z, got.cam_z);
        field("cam_pitch", e.cam_pitch, got.cam_pitch);
        field("cam_yaw", e.cam_yaw, got.cam_yaw);
        field("updated", e.updated, got.updated);
    endfunction
endclass

module tb_orbit_camera_update_unit;

    localparam int LIMIT_CYCLES  = 2000000;
    localparam int ITEMS_PER_SET = 220;
    localparam int LONG_HOLD     = 400;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [ocu_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [ocu_pkg::CFG_W-1:0]     cfg_data;

    ocu_item_if   item ();
    ocu_result_if result ();

    camera_scoreboard camera_sb = new();

    // sender side inserts random idle gaps only while this is set; cleared for a stretch of pure streaming
    bit send_gaps  = 1'b1;
    bit recv_gaps  = 1'b1;
    int cycle_cnt  = 0;
    int hold_left  = 0;
    bit hold_done  = 1'b0;

    orbit_camera_update_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // watchdog on total run length
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT_CYCLES)
        begin
            $display("[orbit_camera_update_unit] ERROR");
            $finish;
        end
    end

    // monitors: predict on every accepted request, check every accepted result
    always @(posedge clk)
    begin
        if (rst_n && item.valid && item.ready)
            camera_sb.note_request(item.data);
        if (rst_n && result.valid && result.ready)
            camera_sb.check_result(result.data);
    end

    // result side: random stalls, plus one long hold-off once traffic is flowing
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left     <= hold_left - 1;
            result.ready  <= 1'b0;
        end
        else if (!hold_done && camera_sb.accepted == 300)
        begin
            hold_done    <= 1'b1;
            hold_left    <= LONG_HOLD;
            result.ready <= 1'b0;
        end
        else
            result.ready <= !(recv_gaps && $urandom_range(99) < 8);
    end

    task automatic write_reg(logic [ocu_pkg::CFG_IDX_W-1:0] idx,
                             logic [ocu_pkg::CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        camera_sb.set_reg(idx, val);
        @(posedge clk);
    endtask

    // block until every predicted result has come back, then let the pipe settle
    task automatic drain();
        item.valid <= 1'b0;
        @(posedge clk);
        while (camera_sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
    endtask

    // offer one request and hold valid until it is taken; valid stays high after
    task automatic send_request(ocu_pkg::item_t it);
        if (send_gaps && $urandom_range(99) < 8)
        begin
            item.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        item.valid <= 1'b1;
        item.data  <= it;
        @(posedge clk);
        while (!item.ready)
            @(posedge clk);
    endtask

    function automatic logic signed [15:0] rand_delta();
        int sel;
        sel = $urandom_range(99);
        if (sel < 60)
            return 16'($signed($urandom_range(100)) - 50);
        else if (sel < 75)
            return ($urandom_range(1)) ? 16'sh7fff : 16'sh8000;
        else
            return 16'($urandom);
    endfunction

    function automatic logic signed [31:0] rand_pos();
        int sel;
        sel = $urandom_range(99);
        if (sel < 8)
            return 32'sh7fffffff - 32'($urandom_range(5000));
        else if (sel < 16)
            return 32'sh80000000 + 32'($urandom_range(5000));
        return 32'($urandom);
    endfunction

    function automatic ocu_pkg::item_t rand_request();
        ocu_pkg::item_t it;
        it.mouse_dx = rand_delta();
        it.mouse_dy = rand_delta();
        it.pad_dx   = rand_delta();
        it.pad_dy   = rand_delta();
        it.char_x   = rand_pos();
        it.char_y   = rand_pos();
        it.char_z   = rand_pos();
        it.bypass   = ($urandom_range(99) < 10);
        return it;
    endfunction

    function automatic ocu_pkg::item_t make_request(int dx, int dy, int px, int py,
                                                    logic signed [31:0] cpos, bit byp);
        ocu_pkg::item_t it;
        it.mouse_dx = 16'(dx);
        it.mouse_dy = 16'(dy);
        it.pad_dx   = 16'(px);
        it.pad_dy   = 16'(py);
        it.char_x   = cpos;
        it.char_y   = cpos;
        it.char_z   = -cpos;
        it.bypass   = byp;
        return it;
    endfunction

    int sens_set [7] = '{2560, 3, 65535, 3, 65535, 1000, 0};
    int rad_set  [7] = '{17920, 2560, 262144, 262144, 2560, 100000, 0};

    initial
    begin
        int s;
        int r;
        item.valid    = 1'b0;
        item.data     = '0;
        result.ready  = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = ocu_pkg::REG_SENSITIVITY;
        cfg_data      = '0;
        rst_n         = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, bypass, pitch clamp both ways, position saturation
        send_request(make_request(0, 0, 0, 0, 0, 0));
        send_request(make_request(32767, 32767, 32767, 32767, 32'sh7fffffff, 0));
        send_request(make_request(-32768, -32768, -32768, -32768, 32'sh80000000, 0));
        send_request(make_request(-32768, -32768, -32768, -32768, 32'sh7fffff00, 0));
        send_request(make_request(5, 7, -3, 2, 32'sh12345678, 1));
        send_request(make_request(32767, 32767, 32767, 32767, 32'shffffffff, 1));
        send_request(make_request(-32768, -32768, -32768, -32768, 32'sh80000000, 1));
        send_request(make_request(1, -1, 1, -1, 32'sh80000100, 0));
        send_request(make_request(4096, 400, 4096, 400, 0, 0));
        send_request(make_request(-8192, -900, 0, 0, 32'sh7ffff000, 0));
        send_request(make_request(0, 1638, 0, 0, 0, 0));
        send_request(make_request(0, -1638, 0, -1, 0, 0));
        drain();

        for (int p = 0; p < 8; p++)
        begin
            // pick the register setting for this phase; phase 6 and the last one are random
            s = (p < 7) ? sens_set[p] : $urandom_range(65535, 3);
            r = (p < 7) ? rad_set[p] : $urandom_range(262144, 2560);
            if (p == 6)
            begin
                s = $urandom_range(400, 3);
                r = $urandom_range(20000, 2560);
            end
            write_reg(ocu_pkg::REG_SENSITIVITY, ocu_pkg::CFG_W'(s));
            write_reg(ocu_pkg::REG_ORBIT_RADIUS, ocu_pkg::CFG_W'(r));
            // phase 2 streams with no gaps on either side
            send_gaps = (p != 2);
            recv_gaps = (p != 2);
            for (int n = 0; n < ITEMS_PER_SET - ((p == 7) ? 50 : 0); n++)
            begin
                send_request(rand_request());
                // one mid-phase pause until the block is empty
                if (p == 4 && n == 100)
                    drain();
            end
            drain();
        end

        send_gaps = 1'b1;
        recv_gaps = 1'b1;
        repeat (100) @(posedge clk);
        if (camera_sb.mismatches == 0 && camera_sb.expected_q.size() == 0)
            $display("[orbit_camera_update_unit] OK");
        else
            $display("[orbit_camera_update_unit] ERROR");
        $finish;
    end
endmodule
